### hw/rtl/odcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_pkg
// Shared types and constants for the octal DAC command decoder.
// ----------------------------------------------------------------------------
package odcd_pkg;

    // Fixed field widths of the command and result words
    localparam int CMD_W  = 16;
    localparam int CODE_W = 12;
    localparam int CHAN_W = 3;

    // Control command patterns (bits 15:13 of the command word)
    localparam logic [2:0] CTRL_GAIN_REF = 3'b100;
    localparam logic [2:0] CTRL_CLEAR    = 3'b111;

    // Operation applied to each channel during the sweep
    typedef enum logic [1:0] {
        OP_NONE,
        OP_DATA,
        OP_LDAC,
        OP_CLR
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DRAIN
    } t_state;

    // Channel memory access: one address, read or write in a cycle
    typedef struct packed {
        logic                rd_en;
        logic                wr_in;
        logic                wr_out;
        logic [CHAN_W-1:0]   addr;
        logic [CODE_W-1:0]   in_data;
        logic [CODE_W-1:0]   out_data;
    } t_mem_req;

endpackage
`default_nettype wire

### hw/rtl/odcd_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_cmd_if
// Command channel: command word or LDAC pulse event.
// ----------------------------------------------------------------------------
interface odcd_cmd_if;
    import odcd_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [CMD_W-1:0]  command_word;

    modport source (output valid, output action, output command_word, input ready);
    modport sink   (input valid, input action, input command_word, output ready);
endinterface
`default_nettype wire

### hw/rtl/odcd_res_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_res_if
// Result channel: one word per channel whose output changed.
// ----------------------------------------------------------------------------
interface odcd_res_if;
    import odcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  channel;
    logic [CODE_W-1:0]  code;
    logic               gain_double;
    logic               use_vdd_ref;
    logic               last;

    modport source (output valid, output channel, output code, output gain_double,
                    output use_vdd_ref, output last, input ready);
    modport sink   (input valid, input channel, input code, input gain_double,
                    input use_vdd_ref, input last, output ready);
endinterface
`default_nettype wire

### hw/rtl/odcd_apb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_apb_cfg
// APB register slave holding the LDAC tie-off setting.
// ----------------------------------------------------------------------------
module odcd_apb_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic             o_ldac_tied_low
);
    import odcd_pkg::*;

    localparam logic REG_LDAC = 1'b0;

    logic r_ldac_tied_low;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // ldac_tied_low, resets to 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldac_tied_low <= 1'b1;
        end else if (wr_en && paddr[2] == REG_LDAC) begin
            r_ldac_tied_low <= pwdata[0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LDAC) begin
            prdata[0] = r_ldac_tied_low;
        end
    end

    assign o_ldac_tied_low = r_ldac_tied_low;
endmodule
`default_nettype wire

### hw/rtl/odcd_chan_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_chan_mem
// Input and output code memories, one entry per channel, registered read.
// ----------------------------------------------------------------------------
module odcd_chan_mem #(
    parameter int CHANNEL_COUNT = 8,
    parameter int CODE_BITS     = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire odcd_pkg::t_mem_req         i_req,
    output logic [odcd_pkg::CODE_W-1:0]     o_in_q,
    output logic [odcd_pkg::CODE_W-1:0]     o_out_q
);
    import odcd_pkg::*;

    localparam int ADDR_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [CODE_BITS-1:0]     mem_in  [CHANNEL_COUNT];
    logic [CODE_BITS-1:0]     mem_out [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] r_in_vld;
    logic [CHANNEL_COUNT-1:0] r_out_vld;
    logic [CODE_BITS-1:0]     r_in_q;
    logic [CODE_BITS-1:0]     r_out_q;
    logic [ADDR_W-1:0]        addr;

    assign addr = i_req.addr[ADDR_W-1:0];

    // memory writes
    always_ff @(posedge i_clk) begin
        if (i_req.wr_in) begin
            mem_in[addr] <= i_req.in_data[CODE_BITS-1:0];
        end
        if (i_req.wr_out) begin
            mem_out[addr] <= i_req.out_data[CODE_BITS-1:0];
        end
    end

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= '0;
            r_out_vld <= '0;
        end else begin
            if (i_req.wr_in) begin
                r_in_vld[addr] <= 1'b1;
            end
            if (i_req.wr_out) begin
                r_out_vld[addr] <= 1'b1;
            end
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_in_q  <= r_in_vld[addr]  ? mem_in[addr]  : '0;
            r_out_q <= r_out_vld[addr] ? mem_out[addr] : '0;
        end
    end

    assign o_in_q  = CODE_W'(r_in_q);
    assign o_out_q = CODE_W'(r_out_q);
endmodule
`default_nettype wire

### hw/rtl/odcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odcd_ctrl
// Command decode and per-channel read-modify-write sweep with result output.
// ----------------------------------------------------------------------------
module odcd_ctrl #(
    parameter int CHANNEL_COUNT = 8,
    parameter int CODE_BITS     = 12
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_ldac_tied_low,
    odcd_cmd_if.sink                        i_cmd,
    odcd_res_if.source                      o_res,
    output odcd_pkg::t_mem_req              o_mem_req,
    input  wire logic [odcd_pkg::CODE_W-1:0] i_in_q,
    input  wire logic [odcd_pkg::CODE_W-1:0] i_out_q
);
    import odcd_pkg::*;

    localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNEL_COUNT - 1);

    t_state               r_state, n_state;
    logic [CH_W-1:0]      r_ch;
    t_op                  r_op;
    logic [CHAN_W-1:0]    r_wch;
    logic [CODE_BITS-1:0] r_code;
    logic [1:0]           r_gain, r_gain_old, r_ref, r_ref_old;

    // one result held back so the final one can be flagged
    logic                 r_pend_v;
    logic [CH_W-1:0]      r_pend_ch;
    logic [CODE_BITS-1:0] r_pend_code;
    logic                 r_pend_gd, r_pend_vr;

    // output register
    logic                 r_res_v;
    logic [CHAN_W-1:0]    r_res_ch;
    logic [CODE_W-1:0]    r_res_code;
    logic                 r_res_gd, r_res_vr, r_res_last;

    logic                 accept;
    logic [CHAN_W-1:0]    cmd_ch;
    logic                 cmd_ch_ok;
    logic [CHAN_W-1:0]    ch3;
    logic                 grp;
    logic [CODE_BITS-1:0] old_code, in_code, new_code;
    logic                 hit, changed, out_free, eval_adv, push_out;

    assign accept    = i_cmd.valid && i_cmd.ready;
    assign cmd_ch    = i_cmd.command_word[14:12];
    assign cmd_ch_ok = {1'b0, cmd_ch} < 4'(CHANNEL_COUNT);

    // command decode and control bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
            r_ref  <= '0;
        end else if (accept) begin
            r_gain_old <= r_gain;
            r_ref_old  <= r_ref;
            r_wch      <= cmd_ch;
            r_code     <= i_cmd.command_word[11 -: CODE_BITS];
            if (i_cmd.action) begin
                r_op <= OP_LDAC;
            end else if (!i_cmd.command_word[15]) begin
                r_op <= cmd_ch_ok ? OP_DATA : OP_NONE;
            end else if (i_cmd.command_word[15:13] == CTRL_GAIN_REF) begin
                r_op   <= OP_NONE;
                r_gain <= i_cmd.command_word[5:4];
                r_ref  <= i_cmd.command_word[1:0];
            end else if (i_cmd.command_word[15:13] == CTRL_CLEAR) begin
                r_op <= OP_CLR;
                if (i_cmd.command_word[12]) begin
                    r_gain <= '0;
                    r_ref  <= '0;
                end
            end else begin
                r_op <= OP_NONE;
            end
        end
    end

    // evaluate one channel from the registered read data
    assign ch3      = CHAN_W'(r_ch);
    assign grp      = ch3[2];
    assign old_code = i_out_q[CODE_BITS-1:0];
    assign in_code  = i_in_q[CODE_BITS-1:0];
    assign hit      = (r_wch == ch3);

    always_comb begin
        case (r_op)
            OP_LDAC: new_code = in_code;
            OP_DATA: new_code = (hit && i_ldac_tied_low) ? r_code : old_code;
            OP_CLR:  new_code = '0;
            default: new_code = old_code;
        endcase
    end

    assign changed  = (new_code != old_code) || (r_gain[grp] != r_gain_old[grp]) ||
                      (r_ref[grp] != r_ref_old[grp]);
    assign out_free = !r_res_v || o_res.ready;
    assign eval_adv = !changed || !r_pend_v || out_free;
    assign push_out = r_pend_v && out_free &&
                      (((r_state == S_EVAL) && changed) || (r_state == S_DRAIN));

    // next state, memory requests, ready
    always_comb begin
        n_state            = r_state;
        i_cmd.ready        = 1'b0;
        o_mem_req.rd_en    = 1'b0;
        o_mem_req.wr_in    = 1'b0;
        o_mem_req.wr_out   = 1'b0;
        o_mem_req.addr     = ch3;
        o_mem_req.in_data  = CODE_W'(r_op == OP_CLR ? '0 : r_code);
        o_mem_req.out_data = CODE_W'(new_code);
        unique case (r_state)
            S_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_mem_req.rd_en = 1'b1;
                n_state         = S_EVAL;
            end
            S_EVAL: begin
                if (eval_adv) begin
                    o_mem_req.wr_in  = (r_op == OP_CLR) || (r_op == OP_DATA && hit);
                    o_mem_req.wr_out = (r_op != OP_NONE);
                    n_state          = (r_ch == LAST_CH) ? S_DRAIN : S_READ;
                end
            end
            S_DRAIN: begin
                if (!r_pend_v || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_ch <= '0;
            end else if (r_state == S_EVAL && eval_adv && r_ch != LAST_CH) begin
                r_ch <= r_ch + 1'b1;
            end
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (r_state == S_EVAL && changed && eval_adv) begin
            r_pend_v <= 1'b1;
        end else if (r_state == S_DRAIN && push_out) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL && changed && eval_adv) begin
            r_pend_ch   <= r_ch;
            r_pend_code <= new_code;
            r_pend_gd   <= r_gain[grp];
            r_pend_vr   <= r_ref[grp];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v <= 1'b0;
        end else if (push_out) begin
            r_res_v <= 1'b1;
        end else if (o_res.ready) begin
            r_res_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_out) begin
            r_res_ch   <= CHAN_W'(r_pend_ch);
            r_res_code <= CODE_W'(r_pend_code);
            r_res_gd   <= r_pend_gd;
            r_res_vr   <= r_pend_vr;
            r_res_last <= (r_state == S_DRAIN);
        end
    end

    assign o_res.valid       = r_res_v;
    assign o_res.channel     = r_res_ch;
    assign o_res.code        = r_res_code;
    assign o_res.gain_double = r_res_gd;
    assign o_res.use_vdd_ref = r_res_vr;
    assign o_res.last        = r_res_last;

    // checks
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending result left over in idle");

    a_stall_needs_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && !eval_adv) |-> (r_pend_v && r_res_v))
        else $error("sweep stalled without a blocked result");

    a_ch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && eval_adv && r_ch != LAST_CH) |=>
            (r_state == S_READ && r_ch == $past(r_ch) + 1'b1))
        else $error("sweep channel did not advance by one");

    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_req.rd_en && (o_mem_req.wr_in || o_mem_req.wr_out)))
        else $error("memory read and write in the same cycle");
endmodule
`default_nettype wire

### hw/rtl/octal_dac_command_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octal_dac_command_decoder
// Device-side model of an eight-channel DAC register interface.
// ----------------------------------------------------------------------------
// Each command word or LDAC event is applied by a sweep over the channels:
// every channel reads its input and output codes from the channel memory
// (S_READ), then is updated and written back (S_EVAL), which stalls while
// the result channel holds back an earlier result. One result word leaves
// per changed channel in ascending order, the last one flagged. A new item
// is taken once the sweep is over; the final result may still sit in the
// output register.
// ldac_tied_low (register 0, reset 1) is written over APB and must only be
// changed while the block is idle.
// ----------------------------------------------------------------------------
module octal_dac_command_decoder #(
    parameter int CHANNEL_COUNT = 8,
    parameter int CODE_BITS     = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    odcd_cmd_if.sink         i_cmd,
    odcd_res_if.source       o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import odcd_pkg::*;

    logic              ldac_tied_low;
    t_mem_req          mem_req;
    logic [CODE_W-1:0] in_q;
    logic [CODE_W-1:0] out_q;

    // configuration register
    odcd_apb_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_ldac_tied_low (ldac_tied_low)
    );

    // channel code memories
    odcd_chan_mem #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .CODE_BITS     (CODE_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_in_q  (in_q),
        .o_out_q (out_q)
    );

    // decoder and sweep sequencer
    odcd_ctrl #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .CODE_BITS     (CODE_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ldac_tied_low (ldac_tied_low),
        .i_cmd           (i_cmd),
        .o_res           (o_res),
        .o_mem_req       (mem_req),
        .i_in_q          (in_q),
        .i_out_q         (out_q)
    );
endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: octal_dac_command_decoder testbench
// Sends command words and LDAC pulses to the decoder and predicts every
// reported channel update from a local copy of the DAC registers. Directed
// tests cover each command class, the LDAC modes and one long receiver
// hold-off, then random traffic runs under both ldac_tied_low settings with
// random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
    import odcd_pkg::*;

    localparam int N_CHAN           = 8;
    localparam int GROUP_SIZE       = 4;
    localparam int SETTLE_CYCLES    = 2 * N_CHAN + 2 + 6;
    localparam int RANDOM_PER_PHASE = 106;
    localparam int PRESSURE_ITEMS   = 16;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 400000;

    // Item kinds on the command channel
    localparam logic ACT_WORD = 1'b0;
    localparam logic ACT_LDAC = 1'b1;

    // APB register map
    localparam logic [2:0] REG_LDAC_TIED_LOW = 3'd0;
    localparam logic [2:0] REG_UNMAPPED      = 3'd4;

    // Command words and control patterns
    localparam logic [CMD_W-1:0] CMD_DATA_RESET = 16'hE000;
    localparam logic [CMD_W-1:0] CMD_FULL_RESET = 16'hF000;
    localparam logic [CMD_W-1:0] CMD_ALL_ONES   = 16'hFFFF;
    localparam logic [2:0]       CTRL_IGNORE_LO = 3'b101;
    localparam logic [2:0]       CTRL_IGNORE_HI = 3'b110;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [CODE_W-1:0] code;
        logic              gain_double;
        logic              use_vdd_ref;
        logic              last;
    } t_dac_update;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    odcd_cmd_if cmd_if ();
    odcd_res_if res_if ();

    // Local copy of the DAC registers
    logic [N_CHAN-1:0][CODE_W-1:0] in_codes;
    logic [N_CHAN-1:0][CODE_W-1:0] out_codes;
    logic [1:0]                    gain_sel;
    logic [1:0]                    vdd_sel;
    logic                          tied_low;

    t_dac_update pending_updates[$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_request = 0;
    bit          send_burst = 1'b0;
    bit          recv_burst = 1'b0;

    octal_dac_command_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("octal_dac_command_decoder test failed");
            $finish;
        end
    end

    function automatic logic [CMD_W-1:0] data_word(input logic [CHAN_W-1:0] ch,
                                                   input logic [CODE_W-1:0] code);
        return {1'b0, ch, code};
    endfunction

    function automatic logic [CMD_W-1:0] gain_word(input logic [1:0] gain,
                                                   input logic [1:0] vref);
        return {CTRL_GAIN_REF, 7'b0, gain, 2'b0, vref};
    endfunction

    // Apply one accepted item to the register copy and queue the channel
    // updates it should report, ascending, last one flagged
    task automatic decode_command(input logic act, input logic [CMD_W-1:0] cmd_word);
        logic [N_CHAN-1:0][CODE_W-1:0] old_out;
        logic [1:0]                    old_gain;
        logic [1:0]                    old_vdd;
        logic [N_CHAN-1:0]             changed;
        logic [CHAN_W-1:0]             ch;
        t_dac_update                   upd;
        int                            i;
        int                            g;
        old_out  = out_codes;
        old_gain = gain_sel;
        old_vdd  = vdd_sel;
        if (act == ACT_LDAC) begin
            out_codes = in_codes;
        end else if (!cmd_word[15]) begin
            ch = cmd_word[14:12];
            in_codes[ch] = cmd_word[CODE_W-1:0];
            if (tied_low) begin
                out_codes[ch] = cmd_word[CODE_W-1:0];
            end
        end else if (cmd_word[15:13] == CTRL_GAIN_REF) begin
            gain_sel = cmd_word[5:4];
            vdd_sel  = cmd_word[1:0];
        end else if (cmd_word[15:13] == CTRL_CLEAR) begin
            in_codes  = '0;
            out_codes = '0;
            // bit 12 set: control bits are cleared too
            if (cmd_word[12]) begin
                gain_sel = '0;
                vdd_sel  = '0;
            end
        end
        for (i = 0; i < N_CHAN; i++) begin
            g = i / GROUP_SIZE;
            changed[i] = (out_codes[i] != old_out[i]) || (gain_sel[g] != old_gain[g]) ||
                         (vdd_sel[g] != old_vdd[g]);
        end
        for (i = 0; i < N_CHAN; i++) begin
            if (changed[i]) begin
                g = i / GROUP_SIZE;
                upd.channel     = i[CHAN_W-1:0];
                upd.code        = out_codes[i];
                upd.gain_double = gain_sel[g];
                upd.use_vdd_ref = vdd_sel[g];
                upd.last        = ((changed >> (i + 1)) == '0);
                pending_updates.push_back(upd);
            end
        end
    endtask

    // Offer one item after a random gap (none in a burst); returns at the accepting edge
    task automatic send_item(input logic act, input logic [CMD_W-1:0] cmd_word);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.action       <= act;
        cmd_if.command_word <= cmd_word;
        do @(posedge i_clk); while (!cmd_if.ready);
        decode_command(act, cmd_word);
    endtask

    // Drop valid, wait for every expected word, then let a silent sweep finish
    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (pending_updates.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup, access, then idle with psel low
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_ldac(input logic value);
        logic [31:0] rd;
        apb_access(1'b1, REG_LDAC_TIED_LOW, {31'b0, value}, rd);
        tied_low = value;
    endtask

    task automatic check_ldac_readback(input logic value);
        logic [31:0] rd;
        apb_access(1'b0, REG_LDAC_TIED_LOW, '0, rd);
        if (rd !== {31'b0, value}) begin
            $error("ldac_tied_low: expected %h, actual %h", {31'b0, value}, rd);
            errors++;
        end
    endtask

    // Register reset value, write/read back, unmapped address ignored
    task automatic test_register_access();
        logic [31:0] rd;
        check_ldac_readback(1'b1);
        write_ldac(1'b0);
        check_ldac_readback(1'b0);
        apb_access(1'b1, REG_UNMAPPED, 32'h1, rd);
        check_ldac_readback(1'b0);
        write_ldac(1'b1);
        check_ldac_readback(1'b1);
    endtask

    // Code writes at the channel and code extremes, including a no-change write
    task automatic test_data_words();
        send_item(ACT_WORD, data_word(3'd0, 12'h000));
        send_item(ACT_WORD, data_word(3'd0, 12'hFFF));
        send_item(ACT_WORD, data_word(3'd7, 12'hFFF));
        send_item(ACT_WORD, data_word(3'd3, 12'hA5C));
        send_item(ACT_WORD, data_word(3'd7, 12'h000));
    endtask

    // Gain and reference bits per group, don't-care bits set
    task automatic test_gain_and_reference();
        send_item(ACT_WORD, gain_word(2'b11, 2'b00));
        send_item(ACT_WORD, gain_word(2'b01, 2'b10));
        send_item(ACT_WORD, {CTRL_GAIN_REF, 13'h1FFF});
        send_item(ACT_WORD, gain_word(2'b00, 2'b00));
    endtask

    // Unused control patterns, and LDAC with outputs already current
    task automatic test_ignored_controls();
        send_item(ACT_WORD, {CTRL_IGNORE_LO, 13'h0000});
        send_item(ACT_WORD, {CTRL_IGNORE_LO, 13'h1FFF});
        send_item(ACT_WORD, {CTRL_IGNORE_HI, 13'h0000});
        send_item(ACT_WORD, {CTRL_IGNORE_HI, 13'h1FFF});
        send_item(ACT_LDAC, CMD_ALL_ONES);
    endtask

    // Data reset keeps the control bits, full reset clears them
    task automatic test_clear_commands();
        send_item(ACT_WORD, gain_word(2'b11, 2'b11));
        send_item(ACT_WORD, data_word(3'd5, 12'h800));
        send_item(ACT_WORD, CMD_DATA_RESET | 16'h05A5);
        send_item(ACT_WORD, data_word(3'd2, 12'h001));
        send_item(ACT_WORD, CMD_ALL_ONES);
        send_item(ACT_WORD, CMD_FULL_RESET);
    endtask

    // With LDAC held off, writes stay in the input registers until a pulse
    task automatic test_deferred_update();
        wait_idle();
        write_ldac(1'b0);
        send_item(ACT_WORD, data_word(3'd1, 12'h123));
        send_item(ACT_WORD, data_word(3'd6, 12'hFFF));
        send_item(ACT_LDAC, '0);
        send_item(ACT_LDAC, CMD_ALL_ONES);
        send_item(ACT_WORD, data_word(3'd1, 12'h000));
        send_item(ACT_WORD, CMD_DATA_RESET);
        wait_idle();
        write_ldac(1'b1);
    endtask

    // Receiver holds off while full eight-channel runs keep coming
    task automatic test_backpressure();
        int n;
        send_burst   = 1'b1;
        hold_request = HOLD_CYCLES;
        for (n = 0; n < PRESSURE_ITEMS; n++) begin
            send_item(ACT_WORD, (n % 2 == 0) ? gain_word(2'b11, 2'b11) : gain_word(2'b00, 2'b00));
        end
        send_burst = 1'b0;
        wait_idle();
    endtask

    // Random traffic, mostly well-formed commands, under both LDAC modes
    task automatic test_random_traffic();
        int               phase;
        int               n;
        int               r;
        logic             act;
        logic [CMD_W-1:0] w;
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_ldac(phase % 2 == 1);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 30 == 0) begin
                    send_burst = ($urandom_range(0, 3) == 0);
                end
                r   = $urandom_range(0, 99);
                act = (r < 15) ? ACT_LDAC : ACT_WORD;
                w   = CMD_W'($urandom_range(0, 16'hFFFF));
                if (act == ACT_WORD) begin
                    if (r < 62) begin
                        w[15] = 1'b0;
                    end else if (r < 78) begin
                        w[15:13] = CTRL_GAIN_REF;
                    end else if (r < 84) begin
                        w[15:13] = CTRL_CLEAR;
                    end else if (r < 92) begin
                        w[15:13] = ($urandom_range(0, 1) == 1) ? CTRL_IGNORE_LO : CTRL_IGNORE_HI;
                    end
                end
                send_item(act, w);
            end
        end
        send_burst = 1'b0;
    endtask

    // Result receiver: random stall after every word, plus requested hold-off
    initial begin : result_sink
        int stall_left;
        int long_hold;
        stall_left = 0;
        long_hold  = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                long_hold    = hold_request;
                hold_request = 0;
            end
            if (res_if.valid && res_if.ready) begin
                if ($urandom_range(0, 31) == 0) begin
                    recv_burst = ($urandom_range(0, 2) == 0);
                end
                stall_left = recv_burst ? 0 : $urandom_range(0, 15);
            end
            if (long_hold > 0) begin
                long_hold--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted word with the oldest expected update
    always @(posedge i_clk) begin : check_results
        t_dac_update want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_updates.size() == 0) begin
                $error("unexpected word: channel %0d code %h", res_if.channel, res_if.code);
                errors++;
            end else begin
                want = pending_updates.pop_front();
                if (res_if.channel !== want.channel) begin
                    $error("channel: expected %0d, actual %0d", want.channel, res_if.channel);
                    errors++;
                end
                if (res_if.code !== want.code) begin
                    $error("code: expected %h, actual %h", want.code, res_if.code);
                    errors++;
                end
                if (res_if.gain_double !== want.gain_double) begin
                    $error("gain_double: expected %b, actual %b", want.gain_double,
                           res_if.gain_double);
                    errors++;
                end
                if (res_if.use_vdd_ref !== want.use_vdd_ref) begin
                    $error("use_vdd_ref: expected %b, actual %b", want.use_vdd_ref,
                           res_if.use_vdd_ref);
                    errors++;
                end
                if (res_if.last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, res_if.last);
                    errors++;
                end
            end
        end
    end

    // Test sequence
    initial begin
        i_rst_n             <= 1'b0;
        cmd_if.valid        <= 1'b0;
        cmd_if.action       <= ACT_WORD;
        cmd_if.command_word <= '0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_codes  = '0;
        out_codes = '0;
        gain_sel  = '0;
        vdd_sel   = '0;
        tied_low  = 1'b1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_data_words();
        test_gain_and_reference();
        test_ignored_controls();
        test_clear_commands();
        test_deferred_update();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (errors == 0) begin
            $display("octal_dac_command_decoder test passed");
        end else begin
            $display("octal_dac_command_decoder test failed");
        end
        $finish;
    end

endmodule
